@@ sv/sobel_pkg.sv @@
package sobel_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int ROW_W        = 10;
	localparam int RST_WIDTH    = 24;
	localparam int RST_HEIGHT   = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 window, row-major, oldest row at index 0
	typedef pix_t [8:0] win_t;

	// |gx| + |gy| with gx = {-1,0,1,-2,0,2,-1,0,1}, gy = {1,2,1,0,0,0,-1,-2,-1},
	// saturated to the pixel range
	function automatic pix_t sobel_mag(input win_t w);
		logic [9:0]  gx_pos;
		logic [9:0]  gx_neg;
		logic [9:0]  gy_pos;
		logic [9:0]  gy_neg;
		logic [9:0]  ax;
		logic [9:0]  ay;
		logic [10:0] sum;
		gx_pos = 10'(w[2]) + {1'b0, w[5], 1'b0} + 10'(w[8]);
		gx_neg = 10'(w[0]) + {1'b0, w[3], 1'b0} + 10'(w[6]);
		gy_pos = 10'(w[0]) + {1'b0, w[1], 1'b0} + 10'(w[2]);
		gy_neg = 10'(w[6]) + {1'b0, w[7], 1'b0} + 10'(w[8]);
		ax = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
		ay = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
		sum = 11'(ax) + 11'(ay);
		return (sum > 11'd255) ? pix_t'(8'hFF) : sum[PIX_W-1:0];
	endfunction

endpackage

@@ sv/sobel_ram.sv @@
module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/sobel_edge_stream_core.sv @@
// Sobel edge detector on a raster-order grayscale pixel stream.
//
// Input channel (in_valid/in_ready, pixel): one 8-bit pixel per transaction,
// row by row. Output channel (out_valid/out_ready, edge_res, last): one
// |gx|+|gy| value, saturated to 255, for every pixel whose 3x3 neighborhood
// lies fully inside the frame; the first two rows and the first two columns
// give nothing. last marks the result of the final pixel of a frame, after
// which the column and row counters restart.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
// image width, index 1 the image height; other indexes are dropped. Sizes are
// clamped to 3..MAX_WIDTH and 3..1024. Write only while no pixel is in flight.
// Throughput is one pixel per clock while the receiver does not stall. A pixel
// passes the registered line-buffer read (stage 1) and the window update
// (stage 2); the magnitude is computed from the window straight into the
// output register.
// When the receiver stalls, the output register holds and the two inner
// stages fill up; in_ready drops once all three are occupied.
// Reset clears counters, window and stage valids and restores 24x20. The
// line buffers are not cleared: their unwritten entries only reach border
// positions, which never give a result.
module sobel_edge_stream_core #(
	parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sobel_pkg::PIX_W-1:0]      pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sobel_pkg::PIX_W-1:0]      edge_res,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > sobel_pkg::CFG_W) ? CW + 1 : sobel_pkg::CFG_W;
	localparam int RW = sobel_pkg::ROW_W;
	localparam int WIDTH_RST = (sobel_pkg::RST_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : sobel_pkg::RST_WIDTH;

	typedef struct packed {
		logic res;
		logic last;
	} tag_t;

	// configuration, kept as the index of the last column / last row
	logic [CW-1:0] col_last_q;
	logic [RW-1:0] row_last_q;
	logic [CW-1:0] col_last_d;
	logic [RW-1:0] row_last_d;
	logic [EW-1:0] width_ext;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          row_end;
	logic          frame_end;
	logic          in_acc;

	logic                    valid_s1;
	tag_t                    tag_s1;
	sobel_pkg::pix_t         px_s1;
	logic [CW-1:0]           idx_s1;
	logic [2*sobel_pkg::PIX_W-1:0] lines_rd;

	logic            valid_s2;
	tag_t            tag_s2;
	sobel_pkg::win_t win_q;

	logic out_free;
	logic s2_go;
	logic s2_free;
	logic s1_go;

	logic            out_valid_q;
	sobel_pkg::pix_t edge_res_q;
	logic            last_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		width_ext = EW'(cfg_data);
		if (width_ext < EW'(3)) begin
			col_last_d = CW'(2);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			col_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			col_last_d = CW'(width_ext - EW'(1));
		end
		if (cfg_data < sobel_pkg::CFG_W'(3)) begin
			row_last_d = RW'(2);
		end else if (cfg_data > sobel_pkg::CFG_W'(sobel_pkg::MAX_HEIGHT)) begin
			row_last_d = RW'(sobel_pkg::MAX_HEIGHT - 1);
		end else begin
			row_last_d = RW'(cfg_data - sobel_pkg::CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CW'(WIDTH_RST - 1);
			row_last_q <= RW'(sobel_pkg::RST_HEIGHT - 1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sobel_pkg::CFG_IMAGE_WIDTH:  col_last_q <= col_last_d;
				sobel_pkg::CFG_IMAGE_HEIGHT: row_last_q <= row_last_d;
				default: ;
			endcase
		end
	end

	// Stall chain: each stage advances when the next one is empty or leaving.
	// A stage item that gives no result leaves without touching the output.
	assign out_free = !out_valid_q || out_ready;
	assign s2_go    = valid_s2 && (!tag_s2.res || out_free);
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s1_go;
	assign in_acc   = in_valid && in_ready;

	// Position counters advance per accepted pixel; a shrunk size mid-frame
	// still ends the row or frame because the compares are "at or beyond".
	assign row_end   = (col_q >= col_last_q);
	assign frame_end = row_end && (row_q >= row_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Both line buffers share one RAM: high byte is two rows up, low byte one
	// row up. Read at accept, write back when the pixel leaves stage 1; the
	// next pixel always addresses a different column, so no bypass is needed.
	sobel_ram #(
		.WIDTH(2 * sobel_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.wr_en  (s1_go),
		.wr_addr(idx_s1),
		.wr_data({lines_rd[sobel_pkg::PIX_W-1:0], px_s1}),
		.rd_en  (in_acc),
		.rd_addr(col_q),
		.rd_data(lines_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1       <= pixel;
			idx_s1      <= col_q;
			tag_s1.res  <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			tag_s1.last <= frame_end;
		end
	end

	// Stage 2: the window itself is the stage payload; shift in the new column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (s1_go) begin
				valid_s2 <= 1'b1;
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= lines_rd[2*sobel_pkg::PIX_W-1:sobel_pkg::PIX_W];
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= lines_rd[sobel_pkg::PIX_W-1:0];
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= px_s1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			tag_s2 <= tag_s1;
		end
	end

	// Output register: load the magnitude of a full window, drop border items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && tag_s2.res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && tag_s2.res) begin
			edge_res_q <= sobel_pkg::sobel_mag(win_q);
			last_q     <= tag_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign edge_res  = edge_res_q;
	assign last      = last_q;

endmodule

@@ sv/sobel_chk.sv @@
module sobel_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sobel_pkg::PIX_W-1:0] edge_res,
	input logic                        last
);

	// pixels accepted whose result or drop is not yet seen at the output;
	// border pixels leave silently, so only an upper bound is tracked
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= (pend_q == 3'd7) ? pend_q : pend_q + 3'd1;
		end else if (out_acc && !in_acc && pend_q != 3'd0) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(edge_res) && $stable(last))
		else $error("result changed while stalled");

	// no result without an earlier accepted pixel
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a pending pixel");

	// with nothing pending, the edge that takes a pixel never also raises out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 && in_acc |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind sobel_edge_stream_core sobel_chk u_sobel_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.edge_res (edge_res),
	.last     (last)
);
